>>> rtl/kfr_pkg.sv
// kfr_pkg: byte codes of the KISS framing used by the frame receiver.
// No dependencies; imported by kiss_frame_receiver_core.
package kfr_pkg;

	localparam logic [7:0] KISS_FEND  = 8'hC0;
	localparam logic [7:0] KISS_FESC  = 8'hDB;
	localparam logic [7:0] KISS_TFEND = 8'hDC;
	localparam logic [7:0] KISS_TFESC = 8'hDD;
	localparam logic [7:0] CMD_RESET  = 8'h86;

	localparam int unsigned LEN_W = 10;

	typedef logic [7:0] byte_t;
	typedef logic [LEN_W-1:0] len_t;

endpackage

>>> rtl/kiss_frame_receiver_core.sv
// kiss_frame_receiver_core: KISS deframer, one received byte per word in,
// unescaped payload words and end-of-frame words out. Depends on kfr_pkg.
//
// Channel   Dir  Words                        Accepted when
// s_axis    in   rx_byte                      s_axis_tvalid & s_axis_tready
// m_axis    out  payload byte or frame end    m_axis_tvalid & m_axis_tready
// cfg       in   accept_command               cfg_we
//
// One byte a cycle sustained while m_axis is not stalled; from input to
// result a byte passes the input register, the decode and the result register.
// Bytes that make no result (FEND outside a frame, command, FESC, overflow)
// still pass through the decode stage.
// Reset: idle, awaiting FEND, accept_command = 0x86, nothing in flight.
// A stalled result holds the decode stage; the input stalls while the decode stage holds a word.
module kiss_frame_receiver_core
	import kfr_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [17:8] frame_length,
	                                    // [18] frame_good, [23:19] zero
	output logic        m_axis_tlast,   // is_frame_end
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata       // accept_command
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_CMD   = 2'd1;
	localparam logic [1:0] PH_FRAME = 2'd2;

	logic [1:0]       phase_q, phase_d;
	logic             esc_q, esc_d;
	logic             ovf_q, ovf_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	byte_t            cmd_q;

	logic  v_s1;
	byte_t rx_s1;

	logic  out_free, fire;
	logic  res_v, res_end, res_good;
	byte_t res_byte, ub;
	len_t  res_len;
	logic  [CNT_W+LEN_W-1:0] cnt_ext;

	logic  m_valid_q, m_last_q, m_good_q;
	byte_t m_byte_q;
	len_t  m_len_q;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign fire          = v_s1 && out_free;
	assign s_axis_tready = !v_s1 || out_free;
	assign cnt_ext       = {{LEN_W{1'b0}}, cnt_q};

	always_comb begin
		phase_d  = phase_q;
		esc_d    = esc_q;
		ovf_d    = ovf_q;
		cnt_d    = cnt_q;
		res_v    = 1'b0;
		res_end  = 1'b0;
		res_good = 1'b0;
		res_byte = '0;
		res_len  = '0;
		ub       = rx_s1;
		priority if (rx_s1 == KISS_FEND) begin
			if (phase_q == PH_FRAME) begin
				res_v    = 1'b1;
				res_end  = 1'b1;
				res_len  = cnt_ext[LEN_W-1:0];
				res_good = (cnt_q != '0) && !ovf_q;
			end
			phase_d = PH_CMD;
			esc_d   = 1'b0;
			ovf_d   = 1'b0;
			cnt_d   = '0;
		end else if (phase_q == PH_CMD) begin
			phase_d = (rx_s1 == cmd_q) ? PH_FRAME : PH_IDLE;
		end else if (phase_q == PH_FRAME) begin
			if (esc_q || rx_s1 != KISS_FESC) begin
				if (esc_q) begin
					priority if (rx_s1 == KISS_TFEND) begin
						ub = KISS_FEND;
					end else if (rx_s1 == KISS_TFESC) begin
						ub = KISS_FESC;
					end else begin
						ub = rx_s1;
					end
				end
				esc_d = 1'b0;
				if (cnt_q < CNT_W'(MAX_FRAME)) begin
					cnt_d    = cnt_q + CNT_W'(1);
					res_v    = 1'b1;
					res_byte = ub;
				end else begin
					ovf_d = 1'b1;
				end
			end else begin
				esc_d = 1'b1;
			end
		end else begin
			phase_d = phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			esc_q     <= 1'b0;
			ovf_q     <= 1'b0;
			cnt_q     <= '0;
			cmd_q     <= CMD_RESET;
			v_s1      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cmd_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
			if (fire) begin
				phase_q <= phase_d;
				esc_q   <= esc_d;
				ovf_q   <= ovf_d;
				cnt_q   <= cnt_d;
			end
			if (fire && res_v) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			rx_s1 <= s_axis_tdata;
		end
		if (fire && res_v) begin
			m_last_q <= res_end;
			m_byte_q <= res_byte;
			m_len_q  <= res_len;
			m_good_q <= res_good;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = {5'b0, m_good_q, m_len_q, m_byte_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_FRAME))
		else $error("byte count above frame limit");

	a_esc_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> phase_q == PH_FRAME)
		else $error("escape pending outside a frame");

	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_last_q |-> m_byte_q == '0)
		else $error("end word carries a payload byte");

	a_byte_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_last_q |-> m_len_q == '0 && !m_good_q)
		else $error("payload word carries frame status");

	a_fend_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rx_s1 == KISS_FEND |=> phase_q == PH_CMD && cnt_q == '0 && !ovf_q)
		else $error("FEND did not restart framing");

endmodule
